// ===== rtl/core/rgbse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbse_pkg
// Shared types, constants and helpers of the RGB-to-gray Sobel edge filter.
// ----------------------------------------------------------------------------
package rgbse_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int CFG_W         = 12;
    localparam int PIX_W         = 8;
    localparam int ROW_W         = 12;
    localparam int CMP_W         = 14;
    localparam int ACC_W         = 24;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

    localparam logic [15:0] W_RED   = 16'd13933;
    localparam logic [15:0] W_GREEN = 16'd46871;
    localparam logic [15:0] W_BLUE  = 16'd4732;

    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic valid;
        logic emit;
        logic last;
    } t_stage_ctl;

    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] edge_value;
        logic             last;
    } t_result;

    function automatic logic [CMP_W-1:0] eff_width(input logic [CFG_W-1:0] fw,
                                                   input logic [CMP_W-1:0] maxw);
        logic [CMP_W-1:0] w;
        w = {{(CMP_W-CFG_W){1'b0}}, fw};
        if (w == '0) begin
            w = {{(CMP_W-1){1'b0}}, 1'b1};
        end
        if (w > maxw) begin
            w = maxw;
        end
        return w;
    endfunction

endpackage

// ===== rtl/core/rgb_gray_sobel_edge_filter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_gray_sobel_edge_filter_core
// RGB pixel stream to gray, 3x3 summed Sobel response of interior pixels.
//
// Usage:
//   Input channel (i_valid / o_ready) takes one RGB pixel per request in
//   raster order; i_frame_start marks the first pixel of a frame and clears
//   the position counters. Output channel (o_valid / i_ready) gives one
//   request per interior pixel, issued when its lower-right neighbour is
//   taken in; o_frame_last flags the last interior pixel of the frame.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes frame_width
//   (index 0) and frame_height (index 1); write only while the block is idle.
//   Throughput: one pixel per cycle while o_ready is high, set by the line
//   store read-modify-write (one read and one write port), which runs on
//   each unstalled cycle, forwarding back-to-back same-column accesses.
//   Path: input stage registers, window stage registers, output register.
//   Reset: counters and window clear, width 640, height 480; line stores
//   are not cleared.
//   Stall: a result waiting at the output is backed by a one-entry skid
//   register; o_ready drops only while that skid register is full.
// ----------------------------------------------------------------------------
module rgb_gray_sobel_edge_filter_core #(
    parameter int MAX_WIDTH = rgbse_pkg::MAX_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [rgbse_pkg::PIX_W-1:0] i_red,
    input  logic [rgbse_pkg::PIX_W-1:0] i_green,
    input  logic [rgbse_pkg::PIX_W-1:0] i_blue,
    input  logic                        i_frame_start,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [rgbse_pkg::PIX_W-1:0] o_edge_value,
    output logic                        o_frame_last,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [rgbse_pkg::CFG_W-1:0] i_cfg_data
);
    import rgbse_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam logic [CMP_W-1:0] MAXW_C = CMP_W'(MAX_WIDTH);
    localparam logic [CMP_W-1:0] ONE_C  = CMP_W'(1);
    localparam logic [CMP_W-1:0] TWO_C  = CMP_W'(2);

    logic [CMP_W-1:0] r_eff_w;
    logic [ROW_W-1:0] r_eff_h;
    logic [AW-1:0]    r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    t_stage_ctl       r_s0_ctl;
    t_stage_ctl       n_s0_ctl;
    logic [AW-1:0]    r_s0_col;
    logic [PIX_W-1:0] r_s0_red, r_s0_green, r_s0_blue;

    t_result          r_out, n_out;
    t_result          r_skid, n_skid;

    logic             en;
    logic             in_acc;
    logic [AW-1:0]    c0;
    logic [ROW_W-1:0] r0;
    logic [CMP_W-1:0] c0x, r0x, c1x, r1x, hx;
    logic [ACC_W-1:0] gray_acc;
    logic [PIX_W-1:0] gray;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [PIX_W-1:0] wr_a, wr_b, rd_a, rd_b;
    t_result          res;

    assign en          = !r_skid.valid;
    assign o_ready     = en;
    assign in_acc      = i_valid && en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w <= eff_width(FRAME_WIDTH_RST, MAXW_C);
            r_eff_h <= FRAME_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_FRAME_WIDTH: begin
                    r_eff_w <= eff_width(i_cfg_data, MAXW_C);
                end
                CFG_FRAME_HEIGHT: begin
                    r_eff_h <= (i_cfg_data == '0) ? ROW_W'(1) : i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        c0  = i_frame_start ? '0 : r_col;
        r0  = i_frame_start ? '0 : r_row;
        c0x = CMP_W'(c0);
        r0x = CMP_W'(r0);
        hx  = CMP_W'(r_eff_h);
        c1x = c0x + ONE_C;
        r1x = r0x + ONE_C;
        if (c1x >= r_eff_w) begin
            n_col = '0;
            n_row = (r1x >= hx) ? '0 : r1x[ROW_W-1:0];
        end else begin
            n_col = c1x[AW-1:0];
            n_row = r0;
        end
        n_s0_ctl.valid = in_acc;
        n_s0_ctl.emit  = (c0x >= TWO_C) && (r0x >= TWO_C) && (c0x < r_eff_w) && (r0x < hx);
        n_s0_ctl.last  = (r0x == hx - ONE_C) && (c0x == r_eff_w - ONE_C);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_s0_ctl <= '0;
        end else if (en) begin
            r_s0_ctl <= n_s0_ctl;
            if (in_acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s0_col   <= c0;
            r_s0_red   <= i_red;
            r_s0_green <= i_green;
            r_s0_blue  <= i_blue;
        end
    end

    assign gray_acc = (ACC_W'(W_RED) * ACC_W'(r_s0_red))
                    + (ACC_W'(W_GREEN) * ACC_W'(r_s0_green))
                    + (ACC_W'(W_BLUE) * ACC_W'(r_s0_blue));
    assign gray = gray_acc[ACC_W-1:ACC_W-PIX_W];

    rgbse_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (en),
        .i_rd_addr (r_s0_col),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_a    (wr_a),
        .i_wr_b    (wr_b),
        .o_rd_a    (rd_a),
        .o_rd_b    (rd_b)
    );

    rgbse_window #(
        .AW (AW)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_ctl     (r_s0_ctl),
        .i_col     (r_s0_col),
        .i_gray    (gray),
        .i_rd_a    (rd_a),
        .i_rd_b    (rd_b),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_a    (wr_a),
        .o_wr_b    (wr_b),
        .o_res     (res)
    );

    always_comb begin
        n_out  = r_out;
        n_skid = r_skid;
        if (!r_out.valid || i_ready) begin
            if (r_skid.valid) begin
                n_out        = r_skid;
                n_skid.valid = 1'b0;
            end else begin
                n_out = res;
            end
        end else if (res.valid) begin
            n_skid = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid  <= 1'b0;
            r_skid.valid <= 1'b0;
        end else begin
            r_out.valid  <= n_out.valid;
            r_skid.valid <= n_skid.valid;
        end
        r_out.edge_value  <= n_out.edge_value;
        r_out.last        <= n_out.last;
        r_skid.edge_value <= n_skid.edge_value;
        r_skid.last       <= n_skid.last;
    end

    assign o_valid      = r_out.valid;
    assign o_edge_value = r_out.edge_value;
    assign o_frame_last = r_out.last;

endmodule

// ===== rtl/core/rgbse_line_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbse_line_mem
// Two line stores of gray pixels, one write and one read port, registered
// read data.
// ----------------------------------------------------------------------------
module rgbse_line_mem #(
    parameter int DEPTH = rgbse_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [AW-1:0]               i_rd_addr,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [rgbse_pkg::PIX_W-1:0] i_wr_a,
    input  logic [rgbse_pkg::PIX_W-1:0] i_wr_b,
    output logic [rgbse_pkg::PIX_W-1:0] o_rd_a,
    output logic [rgbse_pkg::PIX_W-1:0] o_rd_b
);
    import rgbse_pkg::*;

    logic [PIX_W-1:0] mem_a [DEPTH];
    logic [PIX_W-1:0] mem_b [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_a[i_wr_addr] <= i_wr_a;
            mem_b[i_wr_addr] <= i_wr_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_a <= mem_a[i_rd_addr];
            o_rd_b <= mem_b[i_rd_addr];
        end
    end

endmodule

// ===== rtl/core/rgbse_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbse_window
// Line store read stage: forwarding, write-back, 3x3 window and the summed
// Sobel kernel with clamping.
// ----------------------------------------------------------------------------
module rgbse_window #(
    parameter int AW = $clog2(rgbse_pkg::MAX_WIDTH_DEF)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  rgbse_pkg::t_stage_ctl       i_ctl,
    input  logic [AW-1:0]               i_col,
    input  logic [rgbse_pkg::PIX_W-1:0] i_gray,
    input  logic [rgbse_pkg::PIX_W-1:0] i_rd_a,
    input  logic [rgbse_pkg::PIX_W-1:0] i_rd_b,
    output logic                        o_wr_en,
    output logic [AW-1:0]               o_wr_addr,
    output logic [rgbse_pkg::PIX_W-1:0] o_wr_a,
    output logic [rgbse_pkg::PIX_W-1:0] o_wr_b,
    output rgbse_pkg::t_result          o_res
);
    import rgbse_pkg::*;

    t_stage_ctl       r_ctl;
    logic [AW-1:0]    r_col;
    logic [PIX_W-1:0] r_gray;
    logic             r_fwd_hit;
    logic [PIX_W-1:0] r_fwd_a;
    logic [PIX_W-1:0] r_fwd_b;
    logic [PIX_W-1:0] r_w0, r_w1, r_w3, r_w4, r_w5;

    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] top;
    logic [9:0]       pos_sum;
    logic [9:0]       neg_sum;
    logic signed [10:0] diff;
    logic [PIX_W-1:0] clamped;

    assign mid = r_fwd_hit ? r_fwd_a : i_rd_a;
    assign top = r_fwd_hit ? r_fwd_b : i_rd_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl     <= '0;
            r_fwd_hit <= 1'b0;
            r_w0      <= '0;
            r_w1      <= '0;
            r_w3      <= '0;
            r_w4      <= '0;
            r_w5      <= '0;
        end else if (i_en) begin
            r_ctl     <= i_ctl;
            r_fwd_hit <= r_ctl.valid && i_ctl.valid && (r_col == i_col);
            if (r_ctl.valid) begin
                r_w0 <= r_w3;
                r_w1 <= r_w4;
                r_w3 <= top;
                r_w4 <= mid;
                r_w5 <= r_gray;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_col   <= i_col;
            r_gray  <= i_gray;
            r_fwd_a <= r_gray;
            r_fwd_b <= mid;
        end
    end

    assign o_wr_en   = i_en && r_ctl.valid;
    assign o_wr_addr = r_col;
    assign o_wr_a    = r_gray;
    assign o_wr_b    = mid;

    always_comb begin
        pos_sum = 10'(r_w0) + 10'(r_w3) + 10'(r_w1);
        neg_sum = 10'(mid) + 10'(r_w5) + 10'(r_gray);
        diff    = $signed({1'b0, pos_sum}) - $signed({1'b0, neg_sum});
        if (diff < 0) begin
            clamped = '0;
        end else if (diff > 11'sd127) begin
            clamped = 8'd255;
        end else begin
            clamped = {diff[6:0], 1'b0};
        end
    end

    assign o_res.valid      = i_en && r_ctl.valid && r_ctl.emit;
    assign o_res.edge_value = clamped;
    assign o_res.last       = r_ctl.last;

endmodule

// ===== tb/sv/rgb_gray_sobel_edge_filter_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_gray_sobel_edge_filter_core_tb
// Self-checking bench for the RGB-to-gray Sobel edge filter core. A
// line-buffer model of the gray conversion and the summed 3x3 kernel predicts
// every interior-pixel response and its frame-last flag. The checker compares
// each output request in order against those predictions. Test tasks cover
// the reset settings, field extremes, degenerate and maximum frame sizes,
// resizing mid-frame, missing frame starts, a long output stall and random
// frames with random idle gaps on both channels.
// ----------------------------------------------------------------------------
module rgb_gray_sobel_edge_filter_core_tb;
    import rgbse_pkg::*;

    localparam int          LINE_DEPTH = MAX_WIDTH_DEF;
    localparam int unsigned LUMA_R     = 13933;
    localparam int unsigned LUMA_G     = 46871;
    localparam int unsigned LUMA_B     = 4732;
    localparam int          MAX_IDLE   = 13;
    localparam int          RANDOM_PIX = 200;
    localparam int          DRAIN_MAX  = 20000;
    localparam int          SETTLE     = 8;
    localparam int          MAX_REPORT = 50;

    typedef struct {
        logic [PIX_W-1:0] edge_value;
        logic             last;
    } t_edge_result;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_ready;
    logic [PIX_W-1:0] i_red;
    logic [PIX_W-1:0] i_green;
    logic [PIX_W-1:0] i_blue;
    logic             i_frame_start;
    logic             o_valid;
    logic             i_ready;
    logic [PIX_W-1:0] o_edge_value;
    logic             o_frame_last;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic             i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;

    t_edge_result     edge_expected[$];
    logic [PIX_W-1:0] line_prev1 [LINE_DEPTH];
    logic [PIX_W-1:0] line_prev2 [LINE_DEPTH];
    logic [PIX_W-1:0] win [6];
    int unsigned      col_pos;
    int unsigned      row_pos;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    int error_count;
    int random_items;
    bit idle_on;
    int hold_cycles;

    rgb_gray_sobel_edge_filter_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_frame_start (i_frame_start),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_edge_value  (o_edge_value),
        .o_frame_last  (o_frame_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int exp_v, input int act_v);
        if (error_count < MAX_REPORT) begin
            $display("%0t %s: expected %0d, actual %0d", $time, what, exp_v, act_v);
        end
        error_count++;
    endtask

    task automatic sobel_predict(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                                 input logic [PIX_W-1:0] b, input logic fs);
        int unsigned  w;
        int unsigned  h;
        int unsigned  acc;
        int           s;
        logic [7:0]   gray;
        logic [7:0]   top;
        logic [7:0]   mid;
        t_edge_result res;
        w = width_reg;
        if (w < 1) w = 1;
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        h = height_reg;
        if (h < 1) h = 1;
        acc  = LUMA_R * r + LUMA_G * g + LUMA_B * b;
        gray = 8'(acc >> 16);
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        top = line_prev2[col_pos];
        mid = line_prev1[col_pos];
        line_prev2[col_pos] = mid;
        line_prev1[col_pos] = gray;
        if (col_pos >= 2 && row_pos >= 2 && col_pos < w && row_pos < h) begin
            s = 2 * (int'(win[0]) + int'(win[3]) + int'(win[1])
                   - int'(mid) - int'(win[5]) - int'(gray));
            if (s < 0) s = 0;
            if (s > 255) s = 255;
            res.edge_value = 8'(s);
            res.last       = (row_pos == h - 1) && (col_pos == w - 1);
            edge_expected.push_back(res);
        end
        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = top;
        win[4] = mid;
        win[5] = gray;
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] b, input logic fs);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_red         <= r;
        i_green       <= g;
        i_blue        <= b;
        i_frame_start <= fs;
        do @(posedge i_clk); while (!o_ready);
        sobel_predict(r, g, b, fs);
    endtask

    task automatic send_random_pixel(input logic fs);
        send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), fs);
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        while (edge_expected.size() > 0 && waited < DRAIN_MAX) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE) @(posedge i_clk);
        if (edge_expected.size() > 0) begin
            report_mismatch("results outstanding", 0, edge_expected.size());
            edge_expected.delete();
        end
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_W-1:0] value);
        i_valid <= 1'b0;
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_FRAME_WIDTH) width_reg = value;
        else height_reg = value;
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
    endtask

    task automatic send_frames(input int count, input int first_fs);
        int w;
        int h;
        w = (width_reg < 1) ? 1 : ((width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg);
        h = (height_reg < 1) ? 1 : height_reg;
        for (int p = 0; p < count * w * h; p++) begin
            send_random_pixel(p == 0 && first_fs != 0);
        end
    endtask

    task automatic test_reset_defaults();
        idle_on = 1'b1;
        for (int p = 0; p < 2 * 640 + 6; p++) begin
            send_random_pixel(1'b0);
        end
    endtask

    task automatic test_corner_patterns();
        int s;
        idle_on = 1'b1;
        set_frame(12'd5, 12'd5);
        for (int r = 0; r < 5; r++) begin
            for (int c = 0; c < 5; c++) begin
                s = r + c;
                if (s <= 1 || s >= 7) send_pixel(8'hFF, 8'hFF, 8'hFF, s == 0);
                else if (s != 4) send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
                else if (r % 3 == 0) send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
                else if (r % 3 == 1) send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
                else send_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
            end
        end
    endtask

    task automatic test_small_frames();
        idle_on = 1'b1;
        for (int w = 0; w < 3; w++) begin
            set_frame(12'(w), 12'd5);
            for (int p = 0; p < 12; p++) send_random_pixel(p == 0);
        end
        for (int h = 0; h < 3; h++) begin
            set_frame(12'd5, 12'(h));
            for (int p = 0; p < 12; p++) send_random_pixel(p == 0);
        end
        set_frame(12'd3, 12'd3);
        send_frames(2, 1);
    endtask

    task automatic test_widest_frame();
        idle_on = 1'b0;
        set_frame(12'hFFF, 12'd3);
        for (int p = 0; p < 20; p++) send_random_pixel(p == 0);
    endtask

    task automatic test_tallest_frame();
        idle_on = 1'b0;
        set_frame(12'd3, 12'hFFF);
        for (int p = 0; p < 3 * 20; p++) send_random_pixel(p == 0);
    endtask

    task automatic test_mid_frame_resize();
        idle_on = 1'b1;
        set_frame(12'd10, 12'd8);
        for (int p = 0; p < 38; p++) send_random_pixel(p == 0);
        // shrink width while the column counter is past the new limit
        write_reg(CFG_FRAME_WIDTH, 12'd6);
        for (int p = 0; p < 18; p++) send_random_pixel(1'b0);
        write_reg(CFG_FRAME_HEIGHT, 12'd5);
        for (int p = 0; p < 31; p++) send_random_pixel(1'b0);
        send_frames(1, 1);
    endtask

    task automatic test_missing_frame_start();
        idle_on = 1'b1;
        set_frame(12'd7, 12'd4);
        send_frames(3, 1);
    endtask

    task automatic test_output_stall();
        idle_on = 1'b0;
        set_frame(12'd8, 12'd6);
        hold_cycles = 300;
        send_frames(1, 1);
    endtask

    task automatic test_random_frames();
        int  w;
        int  h;
        int  frames;
        int  npix;
        bit  omit_fs;
        while (random_items < RANDOM_PIX) begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(3, 16);
            h = $urandom_range(3, 10);
            set_frame(12'(w), 12'(h));
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                idle_on = ($urandom_range(0, 3) != 0);
                omit_fs = (f > 0) && ($urandom_range(0, 4) == 0);
                npix    = w * h;
                // truncate a frame now and then
                if ($urandom_range(0, 7) == 0) npix = $urandom_range(1, w * h);
                for (int p = 0; p < npix; p++) begin
                    send_random_pixel((p == 0 && !omit_fs) || ($urandom_range(0, 59) == 0));
                    random_items++;
                end
            end
        end
    endtask

    initial begin : ready_driver
        int stall;
        i_ready = 1'b0;
        forever begin
            stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (hold_cycles > 0) begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_edge_result exp_res;
        if (i_rst_n === 1'b1 && o_valid && i_ready) begin
            if (edge_expected.size() == 0) begin
                report_mismatch("unexpected edge_value", -1, o_edge_value);
            end else begin
                exp_res = edge_expected.pop_front();
                if (o_edge_value !== exp_res.edge_value) begin
                    report_mismatch("edge_value", exp_res.edge_value, o_edge_value);
                end
                if (o_frame_last !== exp_res.last) begin
                    report_mismatch("frame_last", exp_res.last, o_frame_last);
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("rgb_gray_sobel_edge_filter_core_tb NOT OK");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_red         = '0;
        i_green       = '0;
        i_blue        = '0;
        i_frame_start = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_FRAME_WIDTH;
        i_cfg_data    = '0;
        error_count   = 0;
        random_items  = 0;
        idle_on       = 1'b1;
        hold_cycles   = 0;
        width_reg     = FRAME_WIDTH_RST;
        height_reg    = FRAME_HEIGHT_RST;
        col_pos       = 0;
        row_pos       = 0;
        foreach (win[k]) win[k] = '0;
        foreach (line_prev1[k]) begin
            line_prev1[k] = '0;
            line_prev2[k] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_corner_patterns();
        test_small_frames();
        test_widest_frame();
        test_tallest_frame();
        test_mid_frame_resize();
        test_missing_frame_start();
        test_output_stall();
        test_random_frames();

        i_valid <= 1'b0;
        drain_results();
        if (error_count == 0) begin
            $display("rgb_gray_sobel_edge_filter_core_tb OK");
        end else begin
            $display("rgb_gray_sobel_edge_filter_core_tb NOT OK");
        end
        $finish;
    end

endmodule
